// ===== hw/rtl/arpr_pkg.sv =====
package arpr_pkg;

  localparam int unsigned FRAME_LEN  = 42;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned DESC_DEPTH = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

  localparam logic [31:0] OWN_IP_RESET  = 32'hC0A8_00FA;
  localparam logic [47:0] OWN_MAC_RESET = 48'h0;

  // ARP opcodes.
  localparam logic [7:0] OP_REQUEST = 8'h01;
  localparam logic [7:0] OP_REPLY   = 8'h02;

  // Byte offsets inside the frame.
  localparam logic [POS_W-1:0] POS_HDR_FIRST = 6'd12;
  localparam logic [POS_W-1:0] POS_HDR_LAST  = 6'd21;
  localparam logic [POS_W-1:0] POS_SHA_FIRST = 6'd22;
  localparam logic [POS_W-1:0] POS_SHA_LAST  = 6'd27;
  localparam logic [POS_W-1:0] POS_SPA_FIRST = 6'd28;
  localparam logic [POS_W-1:0] POS_SPA_LAST  = 6'd31;
  localparam logic [POS_W-1:0] POS_THA_FIRST = 6'd32;
  localparam logic [POS_W-1:0] POS_TPA_FIRST = 6'd38;
  localparam logic [POS_W-1:0] POS_LAST      = 6'd41;
  localparam logic [POS_W-1:0] POS_SAT       = 6'd42;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_end;
  } out_item_t;

  // Everything the back end needs to build one reply.
  typedef struct packed {
    logic [47:0] req_mac;
    logic [31:0] req_ip;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
  } reply_desc_t;

  function automatic logic [7:0] mac_octet(input logic [47:0] mac, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_octet(input logic [31:0] ip, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  // Fixed header bytes from the EtherType through the opcode.
  function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] pos, input logic [7:0] opcode);
    logic [7:0] b;
    unique case (pos)
      6'd12:   b = 8'h08;
      6'd13:   b = 8'h06;
      6'd14:   b = 8'h00;
      6'd15:   b = 8'h01;
      6'd16:   b = 8'h08;
      6'd17:   b = 8'h00;
      6'd18:   b = 8'h06;
      6'd19:   b = 8'h04;
      6'd20:   b = 8'h00;
      default: b = opcode;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] reply_byte_at(input reply_desc_t d, input logic [POS_W-1:0] idx);
    logic [7:0] b;
    if (idx < 6'd6) begin
      b = mac_octet(d.req_mac, idx[2:0]);
    end else if (idx < POS_HDR_FIRST) begin
      b = mac_octet(d.own_mac, 3'(idx - 6'd6));
    end else if (idx <= POS_HDR_LAST) begin
      b = hdr_byte(idx, OP_REPLY);
    end else if (idx <= POS_SHA_LAST) begin
      b = mac_octet(d.own_mac, 3'(idx - POS_SHA_FIRST));
    end else if (idx <= POS_SPA_LAST) begin
      b = ip_octet(d.own_ip, 2'(idx - POS_SPA_FIRST));
    end else if (idx < POS_TPA_FIRST) begin
      b = mac_octet(d.req_mac, 3'(idx - POS_THA_FIRST));
    end else begin
      b = ip_octet(d.req_ip, 2'(idx - POS_TPA_FIRST));
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/arp_request_responder_core.sv =====
// A reply's first byte reaches out_item via the descriptor queue and the output register.
// One received byte per cycle unless full; a 42-byte reply leaves one byte per cycle on pop.
// The input stalls only when both reply slots of the descriptor queue are occupied.
// Reset (synchronous, rst_n low): queues empty, parser at frame start, own_ip 192.168.0.250,
// own_mac zero.
module arp_request_responder_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  arpr_pkg::in_item_t                     in_item,
  output logic                                   empty,
  input  logic                                   pop,
  output arpr_pkg::out_item_t                    out_item,
  input  logic                                   cfg_we,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [arpr_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import arpr_pkg::*;

  // Configuration registers. Writes to an index outside the list are dropped.
  logic [31:0] own_ip_r;
  logic [47:0] own_mac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= OWN_IP_RESET;
      own_mac_r <= OWN_MAC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip_r  <= cfg_wdata[31:0];
        CFG_OWN_MAC: own_mac_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: the parser walks the frame byte by byte, checks the ARP request
  // fields and captures the requester's addresses. On the last byte of a good
  // request it hands over one descriptor that snapshots everything the reply needs.
  logic        in_accept;
  logic        desc_push;
  reply_desc_t desc_in;

  assign in_accept = push & ~full;

  arpr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_item),
    .own_ip    (own_ip_r),
    .own_mac   (own_mac_r),
    .desc_push (desc_push),
    .desc      (desc_in)
  );

  // Short queue of pending replies. Because even the shortest good request
  // is as long as a 42-byte reply, the parser keeps pace with the reply stream in steady state.
  logic        desc_pop;
  logic        desc_empty;
  reply_desc_t desc_out;

  arpr_desc_fifo u_desc_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (desc_push),
    .wr_desc (desc_in),
    .rd_en   (desc_pop),
    .rd_desc (desc_out),
    .full    (full),
    .empty   (desc_empty)
  );

  // Back end: a byte counter serializes the 42-byte reply into an output
  // register and retires the descriptor as it loads the last byte.
  logic out_valid;

  arpr_reply_gen u_reply_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (~desc_empty),
    .desc       (desc_out),
    .desc_pop   (desc_pop),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_take   (pop)
  );

  assign empty = ~out_valid;

endmodule

// ===== hw/rtl/arpr_parser.sv =====
module arpr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  arpr_pkg::in_item_t   item,
  input  logic [31:0]          own_ip,
  input  logic [47:0]          own_mac,
  output logic                 desc_push,
  output arpr_pkg::reply_desc_t desc
);
  import arpr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ok_r, ok_nxt;
  logic [47:0]      req_mac_r, req_mac_nxt;
  logic [31:0]      req_ip_r, req_ip_nxt;
  logic             ok_cur, mismatch, ok_now;

  // Compare the byte against the request template or the own address.
  always_comb begin
    ok_cur   = (pos_r == '0) ? 1'b1 : ok_r;
    mismatch = 1'b0;
    if (pos_r >= POS_HDR_FIRST && pos_r <= POS_HDR_LAST) begin
      mismatch = item.frame_byte != hdr_byte(pos_r, OP_REQUEST);
    end else if (pos_r >= POS_TPA_FIRST && pos_r <= POS_LAST) begin
      mismatch = item.frame_byte != ip_octet(own_ip, 2'(pos_r - POS_TPA_FIRST));
    end
    ok_now = ok_cur & ~mismatch;
  end

  always_comb begin
    pos_nxt     = pos_r;
    ok_nxt      = ok_r;
    req_mac_nxt = req_mac_r;
    req_ip_nxt  = req_ip_r;
    if (accept) begin
      if (pos_r >= POS_SHA_FIRST && pos_r <= POS_SHA_LAST) begin
        req_mac_nxt = {req_mac_r[39:0], item.frame_byte};
      end
      if (pos_r >= POS_SPA_FIRST && pos_r <= POS_SPA_LAST) begin
        req_ip_nxt = {req_ip_r[23:0], item.frame_byte};
      end
      if (item.frame_end) begin
        pos_nxt = '0;
        ok_nxt  = 1'b1;
      end else begin
        pos_nxt = (pos_r < POS_SAT) ? pos_r + 6'd1 : POS_SAT;
        ok_nxt  = ok_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ok_r      <= 1'b1;
      req_mac_r <= '0;
      req_ip_r  <= '0;
    end else begin
      pos_r     <= pos_nxt;
      ok_r      <= ok_nxt;
      req_mac_r <= req_mac_nxt;
      req_ip_r  <= req_ip_nxt;
    end
  end

  // Sender fields are complete by the last byte, since a push needs position 41 or later.
  assign desc_push    = accept & item.frame_end & (pos_r >= POS_LAST) & ok_now;
  assign desc.req_mac = req_mac_r;
  assign desc.req_ip  = req_ip_r;
  assign desc.own_mac = own_mac;
  assign desc.own_ip  = own_ip;

endmodule

// ===== hw/rtl/arpr_desc_fifo.sv =====
module arpr_desc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  arpr_pkg::reply_desc_t wr_desc,
  input  logic                  rd_en,
  output arpr_pkg::reply_desc_t rd_desc,
  output logic                  full,
  output logic                  empty
);
  import arpr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DESC_DEPTH);

  reply_desc_t        mem_r [DESC_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     count_r;

  assign full    = count_r == (PTR_W+1)'(DESC_DEPTH);
  assign empty   = count_r == '0;
  assign rd_desc = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DESC_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DESC_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/arpr_reply_gen.sv =====
module arpr_reply_gen (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  desc_valid,
  input  arpr_pkg::reply_desc_t desc,
  output logic                  desc_pop,
  output logic                  out_valid,
  output arpr_pkg::out_item_t   out_item,
  input  logic                  out_take
);
  import arpr_pkg::*;

  logic [POS_W-1:0] idx_r;
  logic             valid_r;
  out_item_t        item_r;
  logic             load;

  // The output register refills in the same cycle its item is taken, if a descriptor is pending.
  assign load      = desc_valid & (~valid_r | out_take);
  assign desc_pop  = load & (idx_r == POS_LAST);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.reply_byte <= reply_byte_at(desc, idx_r);
      item_r.reply_end  <= idx_r == POS_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= (idx_r == POS_LAST) ? '0 : idx_r + 6'd1;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_take) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule
